@@ rtl/clt_pkg.sv @@
package clt_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TEND  = 2'd1;
    localparam logic [1:0] KIND_CEND  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNESCAPED    = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'b001,
        MODE_PLAIN   = 3'b010,
        MODE_QUOTED  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t mk_result(logic [1:0] kind, logic [7:0] data, logic [1:0] err);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        return r;
    endfunction

endpackage

@@ rtl/command_line_tokenizer.sv @@
// Command line tokenizer: splits a NUL-terminated command string into tokens.
// Input channel: one byte per word on in_byte, handshake in_valid / in_stall.
// Output channel: one result word per handshake on kind, out_byte and
// error_code, handshake out_valid / out_stall. kind gives token byte, token
// end, command end or syntax error.
// Each input byte gives zero, one or two result words.
// Throughput: one input byte per cycle while the receiver does not stall and
// each byte gives at most one result; the two results of a byte that gives
// two (NUL ending a plain token) share the single output port in turn.
// A byte is captured in the input register, then parsed into a four-entry
// result queue (held while the queue lacks room), whose head is offered.
// Reset: rst_n clears the parse state to between tokens and empties the
// queue; no input is held.
// When the receiver stalls, result words collect in the queue; in_stall rises
// while a byte waits and fewer than two free entries remain; no word is lost.
module command_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  error_code
);
    import clt_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    logic       accept;
    push_t      push;
    result_t    head;

    assign step     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

    clt_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .push    (push)
    );

    clt_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .head_stall (out_stall),
        .head       (head)
    );

    assign kind       = head.kind;
    assign out_byte   = head.data;
    assign error_code = head.err;

endmodule

@@ rtl/clt_parser.sv @@
module clt_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      byte_in,
    output clt_pkg::push_t  push
);
    import clt_pkg::*;

    mode_t mode_reg, mode_next;
    logic  esc_reg, esc_next;
    logic  has_reg, has_next;
    push_t res;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        has_next  = has_reg;
        res       = '0;
        case (mode_reg)
            MODE_PLAIN:
            begin
                if (byte_in == CH_NUL)
                begin
                    res.count  = 2'd2;
                    res.first  = mk_result(KIND_TEND, CH_NUL, ERR_NONE);
                    res.second = mk_result(KIND_CEND, CH_NUL, ERR_NONE);
                    mode_next  = MODE_BETWEEN;
                    esc_next   = 1'b0;
                    has_next   = 1'b0;
                end
                else if (esc_reg)
                begin
                    esc_next  = 1'b0;
                    res.count = 2'd1;
                    res.first = mk_result(KIND_BYTE, byte_in, ERR_NONE);
                end
                else if (byte_in == CH_QUOTE)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(KIND_ERROR, CH_NUL, ERR_UNESCAPED);
                    mode_next = MODE_BETWEEN;
                    esc_next  = 1'b0;
                    has_next  = 1'b0;
                end
                else if (byte_in inside {CH_SPACE, CH_TAB})
                begin
                    res.count = 2'd1;
                    res.first = mk_result(KIND_TEND, CH_NUL, ERR_NONE);
                    mode_next = MODE_BETWEEN;
                    esc_next  = 1'b0;
                    has_next  = 1'b0;
                end
                else
                begin
                    esc_next  = (byte_in == CH_BACKSLASH);
                    res.count = 2'd1;
                    res.first = mk_result(KIND_BYTE, byte_in, ERR_NONE);
                end
            end
            MODE_QUOTED:
            begin
                if (byte_in == CH_NUL)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(KIND_ERROR, CH_NUL, ERR_UNTERMINATED);
                    mode_next = MODE_BETWEEN;
                    esc_next  = 1'b0;
                    has_next  = 1'b0;
                end
                else if (esc_reg)
                begin
                    esc_next  = 1'b0;
                    has_next  = 1'b1;
                    res.count = 2'd1;
                    res.first = mk_result(KIND_BYTE, byte_in, ERR_NONE);
                end
                else if (byte_in == CH_QUOTE)
                begin
                    res.count = {1'b0, has_reg};
                    res.first = mk_result(KIND_TEND, CH_NUL, ERR_NONE);
                    mode_next = MODE_BETWEEN;
                    esc_next  = 1'b0;
                    has_next  = 1'b0;
                end
                else
                begin
                    esc_next  = (byte_in == CH_BACKSLASH);
                    has_next  = 1'b1;
                    res.count = 2'd1;
                    res.first = mk_result(KIND_BYTE, byte_in, ERR_NONE);
                end
            end
            default:
            begin
                esc_next = 1'b0;
                has_next = 1'b0;
                if (byte_in == CH_NUL)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(KIND_CEND, CH_NUL, ERR_NONE);
                    mode_next = MODE_BETWEEN;
                end
                else if (byte_in inside {CH_SPACE, CH_TAB})
                begin
                    mode_next = MODE_BETWEEN;
                end
                else if (byte_in == CH_QUOTE)
                begin
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    mode_next = MODE_PLAIN;
                    esc_next  = (byte_in == CH_BACKSLASH);
                    res.count = 2'd1;
                    res.first = mk_result(KIND_BYTE, byte_in, ERR_NONE);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            esc_reg  <= 1'b0;
            has_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            has_reg  <= has_next;
        end
    end

    always_comb
    begin
        push = res;
        if (!step)
        begin
            push.count = 2'd0;
        end
    end

endmodule

@@ rtl/clt_out_queue.sv @@
module clt_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  clt_pkg::push_t    push,
    output logic              room,
    output logic              head_valid,
    input  logic              head_stall,
    output clt_pkg::result_t  head
);
    import clt_pkg::*;

    result_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wr_ptr_inc;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && !head_stall;
    assign room       = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import clt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEMS_PHASE  = 570;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    localparam result_t R_NONE  = '{KIND_BYTE, 8'h00, ERR_NONE};
    localparam result_t R_TEND  = '{KIND_TEND, 8'h00, ERR_NONE};
    localparam result_t R_CEND  = '{KIND_CEND, 8'h00, ERR_NONE};
    localparam result_t R_ERR_U = '{KIND_ERROR, 8'h00, ERR_UNESCAPED};
    localparam result_t R_ERR_Q = '{KIND_ERROR, 8'h00, ERR_UNTERMINATED};

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;

    logic       row_typed;
    logic [1:0] row_n;
    result_t    row_r0;
    result_t    row_r1;

    mode_t      tok_mode         = MODE_BETWEEN;
    logic       tok_escape       = 1'b0;
    logic       tok_quoted_bytes = 1'b0;

    result_t    pending_results[$];
    logic [7:0] cmd_bytes[$];
    stim_row_t  dir_rows[0:25];

    int         errors      = 0;
    int         cycle_count = 0;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_req;
    bit         hold_done;

    command_line_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .error_code (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void tokens_clear();
        tok_mode         = MODE_BETWEEN;
        tok_escape       = 1'b0;
        tok_quoted_bytes = 1'b0;
    endfunction

    function automatic int tokenize_byte(input logic [7:0] c,
                                         output result_t r0, output result_t r1);
        int n;
        n  = 0;
        r0 = R_NONE;
        r1 = R_NONE;
        if (tok_mode == MODE_PLAIN)
        begin
            if (c == CH_NUL)
            begin
                r0 = R_TEND;
                r1 = R_CEND;
                n  = 2;
                tokens_clear();
            end
            else if (tok_escape)
            begin
                tok_escape = 1'b0;
                r0 = '{KIND_BYTE, c, ERR_NONE};
                n  = 1;
            end
            else if (c == CH_QUOTE)
            begin
                r0 = R_ERR_U;
                n  = 1;
                tokens_clear();
            end
            else if (c == CH_SPACE || c == CH_TAB)
            begin
                r0 = R_TEND;
                n  = 1;
                tokens_clear();
            end
            else
            begin
                if (c == CH_BACKSLASH)
                    tok_escape = 1'b1;
                r0 = '{KIND_BYTE, c, ERR_NONE};
                n  = 1;
            end
        end
        else if (tok_mode == MODE_QUOTED)
        begin
            if (c == CH_NUL)
            begin
                r0 = R_ERR_Q;
                n  = 1;
                tokens_clear();
            end
            else if (tok_escape)
            begin
                tok_escape       = 1'b0;
                tok_quoted_bytes = 1'b1;
                r0 = '{KIND_BYTE, c, ERR_NONE};
                n  = 1;
            end
            else if (c == CH_QUOTE)
            begin
                if (tok_quoted_bytes)
                begin
                    r0 = R_TEND;
                    n  = 1;
                end
                tokens_clear();
            end
            else
            begin
                if (c == CH_BACKSLASH)
                    tok_escape = 1'b1;
                tok_quoted_bytes = 1'b1;
                r0 = '{KIND_BYTE, c, ERR_NONE};
                n  = 1;
            end
        end
        else
        begin
            tok_escape       = 1'b0;
            tok_quoted_bytes = 1'b0;
            if (c == CH_NUL)
            begin
                r0 = R_CEND;
                n  = 1;
                tokens_clear();
            end
            else if (c == CH_SPACE || c == CH_TAB)
                tok_mode = MODE_BETWEEN;
            else if (c == CH_QUOTE)
                tok_mode = MODE_QUOTED;
            else
            begin
                tok_mode = MODE_PLAIN;
                if (c == CH_BACKSLASH)
                    tok_escape = 1'b1;
                r0 = '{KIND_BYTE, c, ERR_NONE};
                n  = 1;
            end
        end
        return n;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t p0;
        result_t p1;
        result_t exp_r;
        int      n;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                n = tokenize_byte(in_byte, p0, p1);
                if (row_typed)
                begin
                    n  = int'(row_n);
                    p0 = row_r0;
                    p1 = row_r1;
                end
                if (n > 0)
                    pending_results.push_back(p0);
                if (n > 1)
                    pending_results.push_back(p1);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t word: expected none actual kind %0d byte %h err %0d",
                             $time, kind, out_byte, error_code);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (kind !== exp_r.kind)
                    begin
                        errors++;
                        $display("%0t kind: expected %0d actual %0d",
                                 $time, exp_r.kind, kind);
                    end
                    if (out_byte !== exp_r.data)
                    begin
                        errors++;
                        $display("%0t out_byte: expected %h actual %h",
                                 $time, exp_r.data, out_byte);
                    end
                    if (error_code !== exp_r.err)
                    begin
                        errors++;
                        $display("%0t error_code: expected %0d actual %0d",
                                 $time, exp_r.err, error_code);
                    end
                end
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic typed,
                             input logic [1:0] n, input result_t r0, input result_t r1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        row_typed <= typed;
        row_n     <= n;
        row_r0    <= r0;
        row_r1    <= r1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_QUOTE || c == CH_BACKSLASH)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_BACKSLASH)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic build_command();
        int ntok;
        int len;
        int sel;
        cmd_bytes.delete();
        if ($urandom_range(99) < 10)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
                cmd_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        ntok = $urandom_range(0, 4);
        for (int t = 0; t < ntok; t++)
        begin
            repeat ($urandom_range((t == 0) ? 0 : 1, 2))
                cmd_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            sel = $urandom_range(99);
            if (sel < 65)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        cmd_bytes.push_back(CH_BACKSLASH);
                        cmd_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                    else
                        cmd_bytes.push_back(plain_char());
                end
            end
            else if (sel < 92)
            begin
                cmd_bytes.push_back(CH_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        cmd_bytes.push_back(CH_BACKSLASH);
                        cmd_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                    else
                        cmd_bytes.push_back(quoted_char());
                end
                cmd_bytes.push_back(CH_QUOTE);
            end
            else
            begin
                cmd_bytes.push_back(CH_QUOTE);
                cmd_bytes.push_back(CH_QUOTE);
            end
        end
        if ($urandom_range(1))
            cmd_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        // break the sequence now and then
        sel = $urandom_range(99);
        if (sel < 4)
            cmd_bytes.push_back(CH_QUOTE);
        else if (sel < 8)
            cmd_bytes.push_back(CH_BACKSLASH);
        else if (sel < 11)
        begin
            cmd_bytes.push_back(plain_char());
            cmd_bytes.push_back(CH_QUOTE);
        end
        cmd_bytes.push_back(CH_NUL);
    endtask

    initial
    begin
        int sent;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        row_typed     = 1'b0;
        row_n         = 2'd0;
        row_r0        = R_NONE;
        row_r1        = R_NONE;
        hold_req      = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 78;

        dir_rows = '{
            '{CH_NUL,       1'b1, 2'd1, R_CEND, R_NONE},
            '{8'hFF,        1'b1, 2'd1, '{KIND_BYTE, 8'hFF, ERR_NONE}, R_NONE},
            '{CH_NUL,       1'b1, 2'd2, R_TEND, R_CEND},
            '{8'h01,        1'b1, 2'd1, '{KIND_BYTE, 8'h01, ERR_NONE}, R_NONE},
            '{CH_QUOTE,     1'b1, 2'd1, R_ERR_U, R_NONE},
            '{CH_QUOTE,     1'b1, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b1, 2'd0, R_NONE, R_NONE},
            '{CH_TAB,       1'b1, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_SPACE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_BACKSLASH, 1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_BACKSLASH, 1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_BACKSLASH, 1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_NUL,       1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{8'h41,        1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_BACKSLASH, 1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_NUL,       1'b1, 2'd1, R_ERR_Q, R_NONE},
            '{CH_QUOTE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_NUL,       1'b1, 2'd1, R_ERR_Q, R_NONE},
            '{8'h61,        1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_SPACE,     1'b0, 2'd0, R_NONE, R_NONE},
            '{CH_NUL,       1'b1, 2'd1, R_CEND, R_NONE}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].n,
                      dir_rows[i].r0, dir_rows[i].r1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PHASE)
            begin
                build_command();
                foreach (cmd_bytes[j])
                    send_word(cmd_bytes[j], 1'b0, 2'd0, R_NONE, R_NONE);
                sent += cmd_bytes.size();
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            $display("%0t words: expected %0d more actual 0", $time, pending_results.size());
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
